// ----- sv/japanese_charset_judge_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the charset judge
// Shared wrappers so each check sits on one line in the RTL.
// ----------------------------------------------------------------------------
`ifndef JAPANESE_CHARSET_JUDGE_TOP_DEFINES_SVH
`define JAPANESE_CHARSET_JUDGE_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CJJ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define CJJ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/cjj_pkg.sv -----
// ----------------------------------------------------------------------------
// cjj_pkg
// Types, constants and helpers shared by the charset judge modules.
// ----------------------------------------------------------------------------
package cjj_pkg;

	localparam int SCORE_BITS_DEF = 24;
	localparam int QDEPTH         = 4;
	localparam int QPTR_W         = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		V_ASCII = 2'd0,
		V_JIS   = 2'd1,
		V_EUC   = 2'd2,
		V_SJIS  = 2'd3
	} verdict_t;

	localparam logic [7:0] C_ESC    = 8'h1b;
	localparam logic [7:0] C_SS2    = 8'h8e;
	localparam logic [7:0] C_DOLLAR = 8'h24;
	localparam logic [7:0] C_LPAR   = 8'h28;
	localparam logic [7:0] C_RPAR   = 8'h29;
	localparam logic [7:0] C_AT     = 8'h40;
	localparam logic [7:0] C_B      = 8'h42;
	localparam logic [7:0] C_I      = 8'h49;
	localparam logic [7:0] C_J      = 8'h4a;

	localparam logic [6:0] ADD_BIG   = 7'd100;
	localparam logic [6:0] ADD_SMALL = 7'd40;
	localparam logic [6:0] ADD_ONE   = 7'd1;

	// one window snapshot per received byte
	typedef struct packed {
		logic [4:0][7:0] win;
		logic [2:0]      fill;
		logic            last;
	} cjj_entry_t;

	function automatic logic lead_sjis(input logic [7:0] v);
		return (v inside {[8'h81:8'h9f]}) || (v inside {[8'he0:8'hfc]});
	endfunction

endpackage

// ----- sv/cjj_front.sv -----
// ----------------------------------------------------------------------------
// cjj_front
// Accepts bytes, keeps the five-byte window and hands snapshots to the queue.
// ----------------------------------------------------------------------------
module cjj_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         data_byte,
	input  logic               is_last,
	input  logic               byte_valid,
	output logic               byte_ready,
	input  logic               q_full,
	output logic               q_push,
	output cjj_pkg::cjj_entry_t q_wdata
);
	import cjj_pkg::*;

	logic [4:0][7:0] win_q;
	logic [2:0]      fill_q;
	logic [4:0][7:0] win_n;
	logic [2:0]      fill_n;

	assign byte_ready = !q_full;
	assign q_push     = byte_valid && !q_full;

	always_comb begin
		win_n[3:0] = win_q[4:1];
		win_n[4]   = data_byte;
		fill_n     = (fill_q < 3'd5) ? fill_q + 3'd1 : fill_q;
	end

	assign q_wdata = '{win: win_n, fill: fill_n, last: is_last};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			fill_q <= '0;
		end else if (q_push) begin
			if (is_last) begin
				win_q  <= '0;
				fill_q <= '0;
			end else begin
				win_q  <= win_n;
				fill_q <= fill_n;
			end
		end
	end

endmodule

// ----- sv/cjj_queue.sv -----
// ----------------------------------------------------------------------------
// cjj_queue
// Small FIFO of window snapshots between front and back.
// ----------------------------------------------------------------------------
module cjj_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cjj_pkg::cjj_entry_t wdata,
	output logic                full,
	input  logic                pop,
	output logic                valid,
	output cjj_pkg::cjj_entry_t rdata
);
	import cjj_pkg::*;

	cjj_entry_t        mem [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign valid = (cnt_q != '0);
	assign rdata = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ----- sv/cjj_back.sv -----
// ----------------------------------------------------------------------------
// cjj_back
// Scans window snapshots, keeps the scores and issues the verdict.
// ----------------------------------------------------------------------------
`include "japanese_charset_judge_top_defines.svh"

module cjj_back #(
	parameter int SCORE_BITS = cjj_pkg::SCORE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  cjj_pkg::cjj_entry_t q_entry,
	output logic                q_pop,
	output logic                result_valid,
	input  logic                result_ready,
	output logic [1:0]          verdict,
	output logic                decided_early
);
	import cjj_pkg::*;

	logic [1:0]            ph_q;
	logic [1:0]            skip_q, skip_n;
	logic                  pend_q, pend_n;
	logic [1:0]            kana_q, kana_n;
	logic [SCORE_BITS-1:0] sjis_q, sjis_n, euc_q, euc_n;
	verdict_t              verd_q, verd_n, fin_verd;
	logic                  done_q, done_n;
	logic                  res_valid_q, res_early_q;
	verdict_t              res_verd_q;

	logic       last, final_ph, out_free, stall, en, fire_out;
	logic [7:0] b, n1, n2, p1, p2;
	logic       a1, a2, v1, v2;
	logic [6:0] sadd, eadd;
	logic [SCORE_BITS:0] ssum, esum;

	assign last     = q_entry.last;
	assign final_ph = last && (ph_q == 2'd2);
	assign out_free = !res_valid_q || result_ready;
	assign stall    = final_ph && !out_free;
	assign q_pop    = q_valid && !stall && (!last || ph_q == 2'd2);
	assign fire_out = q_valid && final_ph && out_free;

	// operand selection by scan position (two, one or no bytes ahead)
	always_comb begin
		b = '0; n1 = '0; n2 = '0; p1 = '0; p2 = '0;
		a1 = 1'b0; a2 = 1'b0; v1 = 1'b0; v2 = 1'b0; en = 1'b0;
		case (ph_q)
			2'd0: begin
				b = q_entry.win[2]; n1 = q_entry.win[3]; n2 = q_entry.win[4];
				p1 = q_entry.win[1]; p2 = q_entry.win[0];
				a1 = 1'b1; a2 = 1'b1;
				v1 = q_entry.fill >= 3'd4; v2 = q_entry.fill >= 3'd5;
				en = q_entry.fill >= 3'd3;
			end
			2'd1: begin
				b = q_entry.win[3]; n1 = q_entry.win[4];
				p1 = q_entry.win[2]; p2 = q_entry.win[1];
				a1 = 1'b1;
				v1 = q_entry.fill >= 3'd3; v2 = q_entry.fill >= 3'd4;
				en = q_entry.fill >= 3'd2;
			end
			2'd2: begin
				b = q_entry.win[4];
				p1 = q_entry.win[3]; p2 = q_entry.win[2];
				v1 = q_entry.fill >= 3'd2; v2 = q_entry.fill >= 3'd3;
				en = 1'b1;
			end
			default: en = 1'b0;
		endcase
		en = en && q_valid && !stall;
	end

	// one scan step
	always_comb begin
		skip_n = skip_q; pend_n = pend_q; kana_n = kana_q;
		verd_n = verd_q; done_n = done_q;
		sadd = '0; eadd = '0;
		if (!en || done_q) begin
		end else if (skip_q != 2'd0) begin
			skip_n = skip_q - 2'd1;
		end else if (b == C_ESC && a2) begin
			if ((n1 == C_DOLLAR && (n2 == C_B || n2 == C_AT)) ||
			    (n1 == C_LPAR && (n2 == C_B || n2 == C_J))) begin
				verd_n = V_JIS;
				done_n = 1'b1;
			end else begin
				if ((n1 == C_LPAR || n1 == C_RPAR) && n2 == C_I) begin
					verd_n = V_JIS;
					skip_n = 2'd2;
				end
				pend_n = 1'b0;
				kana_n = '0;
			end
		end else if (b < 8'h20) begin
			pend_n = 1'b0;
			kana_n = '0;
			if (v2 && p2 == 8'h81 && (p1 inside {[8'h41:8'h49]})) begin
				verd_n = V_SJIS;
				sadd   = ADD_BIG;
			end else if (v2 && p2 == 8'ha1 && (p1 inside {[8'ha2:8'haa]})) begin
				verd_n = V_EUC;
				eadd   = ADD_BIG;
			end else if (v2 && p2 == 8'h82 && p1 >= 8'ha0) begin
				sadd = ADD_SMALL;
			end else if (v2 && p2 == 8'ha4 && p1 >= 8'ha0) begin
				eadd = ADD_SMALL;
			end
		end else begin
			if (a1) begin
				if ((b == 8'h82 && n1 >= 8'ha0) ||
				    (b == 8'h83 && (n1 inside {[8'h40:8'h9f]})))
					sadd = ADD_ONE;
				else if ((b == 8'ha4 || b == 8'ha5) && n1 >= 8'ha0)
					eadd = ADD_ONE;
			end
			if (pend_q) begin
				if (v1 && (b inside {[8'h40:8'ha0]}) && lead_sjis(p1)) begin
					verd_n = V_SJIS; done_n = 1'b1;
				end else if (v1 && (p1 inside {[8'h81:8'h9f]}) &&
				             ((b inside {[8'h40:8'h7d]}) || (b inside {[8'h7f:8'hfc]}))) begin
					verd_n = V_SJIS; done_n = 1'b1;
				end else if (v1 && (b inside {[8'hfd:8'hfe]}) &&
				             (p1 inside {[8'ha1:8'hfe]})) begin
					verd_n = V_EUC; done_n = 1'b1;
				end else if (v1 && (p1 inside {[8'hfd:8'hfe]}) &&
				             (b inside {[8'ha1:8'hfe]})) begin
					verd_n = V_EUC; done_n = 1'b1;
				end else if (v1 && (b < 8'ha0 || b > 8'hdf) && p1 == C_SS2) begin
					verd_n = V_SJIS; done_n = 1'b1;
				end else if (b <= 8'h7f) begin
					verd_n = V_SJIS; done_n = 1'b1;
				end else begin
					// half-width kana range a7..df scores nothing
					if ((b inside {[8'ha1:8'ha6]}) || (b inside {[8'he0:8'hfe]}) ||
					    b == C_SS2)
						eadd = eadd + ADD_ONE;
					pend_n = 1'b0;
					kana_n = '0;
				end
			end else if (b == C_SS2) begin
				if (!a1) begin
				end else if (n1 inside {[8'ha1:8'hdf]}) begin
					if (kana_q == 2'd1)
						eadd = ADD_BIG;
					if (kana_q != 2'd3)
						kana_n = kana_q + 2'd1;
					skip_n = 2'd1;
				end else begin
					verd_n = V_SJIS; done_n = 1'b1;
				end
			end else if (b inside {[8'h81:8'h9f]}) begin
				verd_n = V_SJIS;
				if (a1 && ((n1 inside {[8'h40:8'h7e]}) || (n1 inside {[8'h80:8'hfc]})))
					done_n = 1'b1;
			end else if (b inside {[8'hfd:8'hfe]}) begin
				verd_n = V_EUC;
				if (a1 && (n1 inside {[8'ha1:8'hfe]}))
					done_n = 1'b1;
			end else if (b > 8'h7f) begin
				pend_n = 1'b1;
				kana_n = '0;
			end
		end
		ssum   = {1'b0, sjis_q} + (SCORE_BITS+1)'(sadd);
		esum   = {1'b0, euc_q} + (SCORE_BITS+1)'(eadd);
		sjis_n = ssum[SCORE_BITS] ? '1 : ssum[SCORE_BITS-1:0];
		euc_n  = esum[SCORE_BITS] ? '1 : esum[SCORE_BITS-1:0];
		fin_verd = verd_n;
		if (!done_n && verd_n == V_ASCII) begin
			if (sjis_n > euc_n)
				fin_verd = V_SJIS;
			else if (sjis_n < euc_n)
				fin_verd = V_EUC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= '0;
			skip_q <= '0;
			pend_q <= 1'b0;
			kana_q <= '0;
			sjis_q <= '0;
			euc_q  <= '0;
			verd_q <= V_ASCII;
			done_q <= 1'b0;
		end else begin
			if (q_pop)
				ph_q <= '0;
			else if (q_valid && !stall)
				ph_q <= ph_q + 2'd1;
			if (fire_out) begin
				skip_q <= '0;
				pend_q <= 1'b0;
				kana_q <= '0;
				sjis_q <= '0;
				euc_q  <= '0;
				verd_q <= V_ASCII;
				done_q <= 1'b0;
			end else if (en) begin
				skip_q <= skip_n;
				pend_q <= pend_n;
				kana_q <= kana_n;
				sjis_q <= sjis_n;
				euc_q  <= euc_n;
				verd_q <= verd_n;
				done_q <= done_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (fire_out)
			res_valid_q <= 1'b1;
		else if (result_ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire_out) begin
			res_verd_q  <= fin_verd;
			res_early_q <= done_n;
		end
	end

	assign result_valid  = res_valid_q;
	assign verdict       = res_verd_q;
	assign decided_early = res_early_q;

	`CJJ_ASSERT_NOW(a_phase_held, ph_q != 2'd0, q_valid && q_entry.last, "phase moved without a last request")
	`CJJ_ASSERT_NEXT(a_state_cleared, fire_out, sjis_q == '0 && euc_q == '0 && !done_q && ph_q == 2'd0, "state not cleared after result")
	`CJJ_ASSERT_NOW(a_pop_only_final, q_pop && q_entry.last, ph_q == 2'd2, "last request popped early")

endmodule

// ----- sv/japanese_charset_judge_top.sv -----
// ----------------------------------------------------------------------------
// japanese_charset_judge_top
// Classifies a byte buffer as ASCII, JIS, EUC-JP or SJIS.
// ----------------------------------------------------------------------------
// Input channel: data_byte/is_last under byte_valid/byte_ready, one request
// per byte; is_last marks the final byte of a buffer.
// Output channel: verdict/decided_early under result_valid/result_ready, one
// result per buffer, none for the other bytes.
// Throughput: one byte per cycle while the queue has room; the final byte of a
// buffer occupies the scanner for its own position and the two look-ahead
// positions left behind, which the single scan unit catches up one per cycle.
// Result: after the final byte is accepted the scanner steps through all three
// positions before result_valid rises, later if earlier bytes are still queued.
// A four-entry queue parts the byte intake from the scanner, and a result
// register parts the scanner from the receiver: while result_ready is low the
// scanner keeps working until it has a second result, then holds and the
// queue fills, after which byte_ready drops.
// Reset clears window, scores, queue pointers and result valid flag; no clearing pass.
// ----------------------------------------------------------------------------
module japanese_charset_judge_top #(
	parameter int SCORE_BITS = cjj_pkg::SCORE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] data_byte,
	input  logic       is_last,
	input  logic       byte_valid,
	output logic       byte_ready,
	output logic [1:0] verdict,
	output logic       decided_early,
	output logic       result_valid,
	input  logic       result_ready
);
	import cjj_pkg::*;

	logic       q_full, q_push, q_valid, q_pop;
	cjj_entry_t q_wdata, q_rdata;

	cjj_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_byte  (data_byte),
		.is_last    (is_last),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_wdata    (q_wdata)
	);

	cjj_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	cjj_back #(
		.SCORE_BITS (SCORE_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_entry       (q_rdata),
		.q_pop         (q_pop),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.verdict       (verdict),
		.decided_early (decided_early)
	);

endmodule

// ----- sim/tb_japanese_charset_judge_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_japanese_charset_judge_top
// Streams byte buffers into the charset judge and compares each per-buffer
// verdict with a behavioural predictor, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_japanese_charset_judge_top;
	import cjj_pkg::*;

	localparam int SB       = 24;
	localparam int WD_LIMIT = 5000;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic [4:0] gap;
		logic       pause; // wait for all verdicts before offering this request
	} req_t;

	typedef struct packed {
		verdict_t v;
		logic     early;
	} verdict_rec_t;

	logic       clk;
	logic       arst_n;
	logic [7:0] data_byte;
	logic       is_last;
	logic       byte_valid;
	logic       byte_ready;
	logic [1:0] verdict;
	logic       decided_early;
	logic       result_valid;
	logic       result_ready;

	japanese_charset_judge_top #(.SCORE_BITS(SB)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.data_byte(data_byte), .is_last(is_last),
		.byte_valid(byte_valid), .byte_ready(byte_ready),
		.verdict(verdict), .decided_early(decided_early),
		.result_valid(result_valid), .result_ready(result_ready)
	);

	// predictor state
	logic [7:0]    win [5];
	int            fill;
	int            skip_n;
	bit            hi_pend;
	int            kana_n;
	logic [SB-1:0] sj_sc, euc_sc;
	verdict_t      cur_v;
	bit            done;

	req_t         pending_reqs[$];
	verdict_rec_t expected_verdicts[$];
	int           n_errors;
	int           n_mismatch;
	bit           all_sent;
	bit           long_hold;

	function automatic logic [SB-1:0] sat(input logic [SB-1:0] s, input int k);
		logic [SB:0] r;
		r = {1'b0, s} + (SB+1)'(k);
		return r[SB] ? {SB{1'b1}} : r[SB-1:0];
	endfunction

	function automatic bit rng(input int v, input int lo, input int hi);
		return v >= lo && v <= hi;
	endfunction

	function automatic bit sj_lead(input int v);
		return rng(v, 8'h81, 8'h9f) || rng(v, 8'he0, 8'hfc);
	endfunction

	task automatic judge_clear();
		for (int i = 0; i < 5; i++) win[i] = 8'h00;
		fill = 0; skip_n = 0; hi_pend = 0; kana_n = 0;
		sj_sc = '0; euc_sc = '0; cur_v = V_ASCII; done = 0;
	endtask

	task automatic judge_fin(input verdict_t v);
		cur_v = v;
		done = 1;
	endtask

	task automatic judge_pos(input int c);
		int ahead, b, n1, n2, p1, p2;
		bit v1, v2;
		ahead = 4 - c;
		b = int'(win[c]);
		n1 = ahead >= 1 ? int'(win[c+1]) : 0;
		n2 = ahead >= 2 ? int'(win[c+2]) : 0;
		v1 = (c - 1) >= 5 - fill;
		v2 = (c - 2) >= 0 && (c - 2) >= 5 - fill;
		p1 = v1 ? int'(win[c-1]) : 0;
		p2 = v2 ? int'(win[c-2]) : 0;
		if (done) return;
		if (skip_n > 0) begin
			skip_n--;
			return;
		end
		if (b == C_ESC && ahead >= 2) begin
			if ((n1 == C_DOLLAR && (n2 == C_B || n2 == C_AT)) ||
					(n1 == C_LPAR && (n2 == C_B || n2 == C_J))) begin
				judge_fin(V_JIS);
				return;
			end
			if ((n1 == C_LPAR || n1 == C_RPAR) && n2 == C_I) begin
				cur_v = V_JIS;
				skip_n = 2;
			end
			hi_pend = 0; kana_n = 0;
			return;
		end
		if (b < 8'h20) begin
			hi_pend = 0; kana_n = 0;
			if (v2 && p2 == 8'h81 && rng(p1, 8'h41, 8'h49)) begin
				cur_v = V_SJIS; sj_sc = sat(sj_sc, 100);
			end else if (v2 && p2 == 8'ha1 && rng(p1, 8'ha2, 8'haa)) begin
				cur_v = V_EUC; euc_sc = sat(euc_sc, 100);
			end else if (v2 && p2 == 8'h82 && p1 >= 8'ha0) begin
				sj_sc = sat(sj_sc, 40);
			end else if (v2 && p2 == 8'ha4 && p1 >= 8'ha0) begin
				euc_sc = sat(euc_sc, 40);
			end
			return;
		end
		if (ahead >= 1) begin
			if ((b == 8'h82 && n1 >= 8'ha0) || (b == 8'h83 && rng(n1, 8'h40, 8'h9f)))
				sj_sc = sat(sj_sc, 1);
			else if ((b == 8'ha4 || b == 8'ha5) && n1 >= 8'ha0)
				euc_sc = sat(euc_sc, 1);
		end
		if (hi_pend) begin
			if (v1 && rng(b, 8'h40, 8'ha0) && sj_lead(p1))
				judge_fin(V_SJIS);
			else if (v1 && rng(p1, 8'h81, 8'h9f) &&
					(rng(b, 8'h40, 8'h7d) || rng(b, 8'h7f, 8'hfc)))
				judge_fin(V_SJIS);
			else if (v1 && rng(b, 8'hfd, 8'hfe) && rng(p1, 8'ha1, 8'hfe))
				judge_fin(V_EUC);
			else if (v1 && rng(p1, 8'hfd, 8'hfe) && rng(b, 8'ha1, 8'hfe))
				judge_fin(V_EUC);
			else if (v1 && (b < 8'ha0 || b > 8'hdf) && p1 == C_SS2)
				judge_fin(V_SJIS);
			else if (b <= 8'h7f)
				judge_fin(V_SJIS);
			else begin
				if (rng(b, 8'ha1, 8'ha6))
					euc_sc = sat(euc_sc, 1);
				else if (rng(b, 8'ha1, 8'hdf))
					;
				else if (rng(b, 8'ha1, 8'hfe) || b == C_SS2)
					euc_sc = sat(euc_sc, 1);
				hi_pend = 0; kana_n = 0;
			end
		end else if (b == C_SS2) begin
			if (ahead < 1)
				;
			else if (rng(n1, 8'ha1, 8'hdf)) begin
				if (kana_n == 1) euc_sc = sat(euc_sc, 100);
				if (kana_n < 3) kana_n++;
				skip_n = 1;
			end else
				judge_fin(V_SJIS);
		end else if (rng(b, 8'h81, 8'h9f)) begin
			cur_v = V_SJIS;
			if (ahead >= 1 && (rng(n1, 8'h40, 8'h7e) || rng(n1, 8'h80, 8'hfc)))
				done = 1;
		end else if (rng(b, 8'hfd, 8'hfe)) begin
			cur_v = V_EUC;
			if (ahead >= 1 && rng(n1, 8'ha1, 8'hfe))
				done = 1;
		end else if (b > 8'h7f) begin
			hi_pend = 1; kana_n = 0;
		end
	endtask

	task automatic judge_byte(input logic [7:0] b, input logic last);
		verdict_rec_t r;
		for (int i = 0; i < 4; i++) win[i] = win[i+1];
		win[4] = b;
		if (fill < 5) fill++;
		if (fill >= 3) judge_pos(2);
		if (!last) return;
		if (fill >= 2) judge_pos(3);
		judge_pos(4);
		r.v = cur_v;
		if (!done && cur_v == V_ASCII) begin
			if (sj_sc > euc_sc) r.v = V_SJIS;
			else if (sj_sc < euc_sc) r.v = V_EUC;
		end
		r.early = done;
		expected_verdicts.push_back(r);
		judge_clear();
	endtask

	// biased byte pool so multi-byte patterns turn up often
	function automatic logic [7:0] pick_byte();
		logic [7:0] pool[20] = '{8'h1b, 8'h24, 8'h28, 8'h29, 8'h42, 8'h40, 8'h4a, 8'h49,
			8'h8e, 8'h81, 8'h82, 8'h83, 8'ha1, 8'ha4, 8'ha5, 8'hfd, 8'hfe, 8'h0a,
			8'h41, 8'hb0};
		case ($urandom_range(0, 9))
			0, 1, 2: return 8'($urandom_range(0, 255));
			3: return 8'($urandom_range(8'ha0, 8'hdf));
			4: return 8'($urandom_range(8'h20, 8'h7e));
			default: return pool[$urandom_range(0, 19)];
		endcase
	endfunction

	task automatic add_buf(input logic [7:0] bytes[$]);
		req_t r;
		foreach (bytes[i]) begin
			r.data  = bytes[i];
			r.last  = (i == bytes.size() - 1);
			r.gap   = ($urandom_range(0, 2) == 0) ? 5'($urandom_range(0, 17)) : 5'd0;
			r.pause = 0;
			pending_reqs.push_back(r);
		end
	endtask

	initial begin
		clk = 0;
		forever begin
			#10 clk = 1;
			#10 clk = 0;
		end
	end

	initial begin
		logic [7:0] bb[$];
		int len, total;
		arst_n = 0;
		judge_clear();
		// directed buffers
		add_buf('{8'h00});
		add_buf('{8'hff});
		add_buf('{8'h1b, 8'h24, 8'h42});
		add_buf('{8'h41, 8'h1b, 8'h28, 8'h4a});
		add_buf('{8'h1b, 8'h28, 8'h49, 8'hb1, 8'h41});
		add_buf('{8'h1b, 8'h24});
		add_buf('{8'h81, 8'h41, 8'h0a, 8'h81, 8'h41});
		add_buf('{8'ha1, 8'ha2, 8'h0d, 8'hfe, 8'h20});
		add_buf('{8'h82, 8'ha0, 8'h0a, 8'h82});
		add_buf('{8'ha4, 8'ha2, 8'h0a, 8'ha5});
		add_buf('{8'h8e, 8'hb1, 8'h8e, 8'hb2, 8'h8e, 8'hb3, 8'h8e, 8'h30});
		add_buf('{8'hfd, 8'ha1});
		add_buf('{8'he5, 8'h41, 8'h80});
		add_buf('{8'ha0, 8'hfe, 8'ha1, 8'h8e, 8'h41, 8'hff});
		total = 0;
		foreach (pending_reqs[i]) total++;
		// random buffers, mostly short, a few long
		while (total < 420) begin
			bb = {};
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
			for (int i = 0; i < len; i++) bb.push_back(pick_byte());
			add_buf(bb);
			if (total < 200 && total + len >= 200) pending_reqs[pending_reqs.size()-len].pause = 1;
			total += len;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1;
	end

	// request driver; a zero gap offers the next request in the cycle after acceptance
	int  drv_wait;
	bit  drv_loaded;
	initial all_sent = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 0;
			data_byte  <= '0;
			is_last    <= 0;
			drv_wait   <= 0;
			drv_loaded <= 0;
		end else begin
			if (byte_valid && byte_ready) begin
				judge_byte(data_byte, is_last);
			end
			if (!byte_valid || byte_ready) begin
				if (!drv_loaded && pending_reqs.size() > 0 && pending_reqs[0].gap != 0) begin
					drv_wait   <= int'(pending_reqs[0].gap) - 1;
					drv_loaded <= 1;
					byte_valid <= 0;
				end else if (drv_loaded && drv_wait > 0) begin
					drv_wait   <= drv_wait - 1;
					byte_valid <= 0;
				end else if (pending_reqs.size() > 0 && pending_reqs[0].pause &&
						(expected_verdicts.size() > 0 || (byte_valid && byte_ready))) begin
					byte_valid <= 0;
					drv_loaded <= 1;
				end else if (pending_reqs.size() > 0) begin
					data_byte  <= pending_reqs[0].data;
					is_last    <= pending_reqs[0].last;
					byte_valid <= 1;
					drv_loaded <= 0;
					void'(pending_reqs.pop_front());
				end else begin
					byte_valid <= 0;
					all_sent   <= 1;
				end
			end
		end
	end

	// result monitor and receiver stalls
	int  rcv_wait;
	int  n_results;
	always @(posedge clk or negedge arst_n) begin
		verdict_rec_t e;
		if (!arst_n) begin
			result_ready <= 0;
			rcv_wait     <= 0;
			n_results    <= 0;
			long_hold    <= 0;
			n_errors     = 0;
			n_mismatch   = 0;
		end else begin
			if (result_valid && result_ready) begin
				n_results <= n_results + 1;
				if (expected_verdicts.size() == 0) begin
					n_errors++;
					if (n_mismatch++ < 10)
						$display("unexpected verdict %0d early %0d", verdict, decided_early);
				end else begin
					e = expected_verdicts.pop_front();
					if (verdict !== e.v || decided_early !== e.early) begin
						n_errors++;
						if (n_mismatch++ < 10)
							$display("verdict mismatch: exp %0d/%0d got %0d/%0d",
								e.v, e.early, verdict, decided_early);
					end
				end
			end
			if (rcv_wait > 0) begin
				rcv_wait     <= rcv_wait - 1;
				result_ready <= 0;
			end else if (!long_hold && n_results >= 20) begin
				long_hold    <= 1;
				rcv_wait     <= 300;
				result_ready <= 0;
			end else if (result_ready && result_valid) begin
				if ($urandom_range(0, 2) == 0) begin
					rcv_wait     <= $urandom_range(0, 17);
					result_ready <= 0;
				end
			end else begin
				result_ready <= 1;
			end
		end
	end

	// watchdog and end of run
	int idle_cycles;
	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((byte_valid && byte_ready) || (result_valid && result_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WD_LIMIT) begin
				$display("status: fail");
				$finish;
			end
			if (all_sent && expected_verdicts.size() == 0 && !byte_valid) begin
				repeat (40) @(posedge clk);
				if (n_errors == 0 && !result_valid)
					$display("status: pass");
				else
					$display("status: fail");
				$finish;
			end
		end
	end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/cjj_pkg.sv
sv/cjj_front.sv
sv/cjj_queue.sv
sv/cjj_back.sv
sv/japanese_charset_judge_top.sv
sim/tb_japanese_charset_judge_top.sv
